FILE: src/sfp_pkg.sv
// Shared types and constants for the sample frame packer.
package sfp_pkg;

   // Frame geometry
   localparam int PAIRS_PER_FRAME = 256;
   localparam int HALF_WORDS      = 2 * PAIRS_PER_FRAME;
   localparam int POS_W           = (HALF_WORDS > 1) ? $clog2(HALF_WORDS) : 1;
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HALF_WORDS - 1);
   localparam logic [15:0]      PAIR_COUNT = 16'(PAIRS_PER_FRAME);

   // Descriptor queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Input mode codes
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_STOP   = 2'd2;
   localparam logic [1:0] MODE_RATE   = 2'd3;

   // Fixed bytes
   localparam logic [7:0] SYNC_BYTE0 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE1 = 8'h55;
   localparam logic [7:0] RATE_ACK   = 8'h72;   // 'r'

   // Byte sequence a descriptor expands into
   typedef enum logic [1:0] {
      KIND_RATE,   // r, ticks low, ticks high
      KIND_HEAD,   // header then word
      KIND_MID,    // word
      KIND_TAIL    // word then checksum
   } sfp_kind_type;

   typedef struct packed {
      sfp_kind_type kind;
      logic [7:0]   seq;
      logic [15:0]  data;
      logic [7:0]   xsum;
   } sfp_desc_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] sample;
      logic [15:0] rate_ticks;
   } sfp_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } sfp_rsp_type;

endpackage

FILE: src/sample_frame_packer.sv
// Top level of the sample frame packer: front end, descriptor queue, byte back end.
//
// Sample words and host commands enter on req_ at up to one transaction per clock while the
// four-entry descriptor queue has room; the result channel moves one byte per clock while
// rsp_stall is low, so the output side sets the sustained rate: a mid-frame sample word gives 2
// bytes, the first word of a frame 7 (header plus word), the last word of a half 3 (word plus
// checksum), a rate command 3, while start, stop and words outside a frame leave no bytes.
// The first byte of a transaction passes through the descriptor queue and then the output
// register before it is presented on rsp_.
module sample_frame_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sfp_pkg::sfp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfp_pkg::sfp_rsp_type rsp_data
);
   import sfp_pkg::*;

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;
   sfp_desc_type q_push_data;
   sfp_desc_type q_head;

   // Classify transactions and track frame state
   sfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Decouple front from back
   sfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head)
   );

   // Emit bytes
   sfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("descriptor pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("descriptor popped from empty queue");

   // A free output register picks up pending work at once
   a_back_busy: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && !rsp_valid) |=> rsp_valid)
      else $error("back end idle with work queued");

   // A byte marked last retires one descriptor
   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_empty) |=> (rsp_valid && rsp_data.last))
      else $error("descriptor retired without last byte");

endmodule

FILE: src/sfp_queue.sv
// Small descriptor queue between the classifying front and the byte back end.
module sfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfp_pkg::sfp_desc_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output sfp_pkg::sfp_desc_type head_data
);
   import sfp_pkg::*;

   sfp_desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff,  count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/sfp_front.sv
// Front end: accepts transactions, tracks framing state, queues byte descriptors.
module sfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sfp_pkg::sfp_req_type  req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output sfp_pkg::sfp_desc_type q_push_data
);
   import sfp_pkg::*;

   logic             streaming_ff, streaming_in;
   logic             frame_active_ff, frame_active_in;
   logic [7:0]       seq_ff, seq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;

   logic       accept;
   logic       frame_start;
   logic       word_in_frame;
   logic       half_end;
   logic [7:0] xor_next;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Word classification
   assign frame_start   = (pos_ff == '0) && streaming_ff;
   assign word_in_frame = frame_start || frame_active_ff;
   assign half_end      = (pos_ff == POS_LAST);
   assign xor_next      = (frame_start ? 8'h00 : xor_ff)
                          ^ req_data.sample[7:0] ^ req_data.sample[15:8];

   // State update and descriptor build
   always_comb begin
      streaming_in    = streaming_ff;
      frame_active_in = frame_active_ff;
      seq_in          = seq_ff;
      pos_in          = pos_ff;
      xor_in          = xor_ff;
      q_push          = 1'b0;
      q_push_data.kind = KIND_MID;
      q_push_data.seq  = seq_ff;
      q_push_data.data = req_data.sample;
      q_push_data.xsum = xor_next;
      if (accept) begin
         case (req_data.mode)
            MODE_START: begin
               seq_in       = 8'h00;
               streaming_in = 1'b1;
            end
            MODE_STOP: begin
               streaming_in = 1'b0;
            end
            MODE_RATE: begin
               q_push           = 1'b1;
               q_push_data.kind = KIND_RATE;
               q_push_data.data = req_data.rate_ticks;
            end
            MODE_SAMPLE: begin
               pos_in = half_end ? '0 : pos_ff + 1'b1;
               if (word_in_frame) begin
                  q_push = 1'b1;
                  xor_in = xor_next;
                  frame_active_in = !half_end;
                  if (frame_start) begin
                     q_push_data.kind = KIND_HEAD;
                     seq_in           = seq_ff + 1'b1;
                  end else if (half_end) begin
                     q_push_data.kind = KIND_TAIL;
                  end
               end
            end
            default: begin
               streaming_in = streaming_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streaming_ff    <= 1'b0;
         frame_active_ff <= 1'b0;
         seq_ff          <= '0;
         pos_ff          <= '0;
         xor_ff          <= '0;
      end else begin
         streaming_ff    <= streaming_in;
         frame_active_ff <= frame_active_in;
         seq_ff          <= seq_in;
         pos_ff          <= pos_in;
         xor_ff          <= xor_in;
      end
   end

endmodule

FILE: src/sfp_back.sv
// Back end: expands queued descriptors to output-register bytes, one per unstalled cycle.
module sfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  sfp_pkg::sfp_desc_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfp_pkg::sfp_rsp_type  rsp_data
);
   import sfp_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sfp_rsp_type rsp_data_ff, rsp_data_in;

   logic       load;
   logic       take;
   logic [2:0] last_idx;
   logic [7:0] cur_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Output register is free when empty or being drained
   assign load  = !rsp_valid_ff || !rsp_stall;
   assign take  = load && !q_empty;
   assign q_pop = take && (idx_ff == last_idx);

   // Byte select per descriptor kind
   always_comb begin
      last_idx = 3'd1;
      cur_byte = q_head.data[7:0];
      case (q_head.kind)
         KIND_RATE: begin
            last_idx = 3'd2;
            case (idx_ff)
               3'd0:    cur_byte = RATE_ACK;
               3'd1:    cur_byte = q_head.data[7:0];
               default: cur_byte = q_head.data[15:8];
            endcase
         end
         KIND_HEAD: begin
            last_idx = 3'd6;
            case (idx_ff)
               3'd0:    cur_byte = SYNC_BYTE0;
               3'd1:    cur_byte = SYNC_BYTE1;
               3'd2:    cur_byte = q_head.seq;
               3'd3:    cur_byte = PAIR_COUNT[7:0];
               3'd4:    cur_byte = PAIR_COUNT[15:8];
               3'd5:    cur_byte = q_head.data[7:0];
               default: cur_byte = q_head.data[15:8];
            endcase
         end
         KIND_MID: begin
            last_idx = 3'd1;
            case (idx_ff)
               3'd0:    cur_byte = q_head.data[7:0];
               default: cur_byte = q_head.data[15:8];
            endcase
         end
         KIND_TAIL: begin
            last_idx = 3'd2;
            case (idx_ff)
               3'd0:    cur_byte = q_head.data[7:0];
               3'd1:    cur_byte = q_head.data[15:8];
               default: cur_byte = q_head.xsum;
            endcase
         end
         default: begin
            last_idx = 3'd1;
         end
      endcase
   end

   // Next output register contents and byte index
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = !q_empty;
      end
      if (take) begin
         rsp_data_in.out_byte = cur_byte;
         rsp_data_in.last     = (idx_ff == last_idx);
         idx_in               = (idx_ff == last_idx) ? 3'd0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
